### rtl/long_press_pairing_mode_timer_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the long-press pairing-mode timer
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef LONG_PRESS_PAIRING_MODE_TIMER_UNIT_ASSERT_SVH
`define LONG_PRESS_PAIRING_MODE_TIMER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define LPPM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lppm assertion failed");

// Consequent must hold in the cycle after the antecedent
`define LPPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lppm assertion failed");

`endif

### rtl/lppm_pkg.sv
// ----------------------------------------------------------------------------
// lppm_pkg
// Shared types, constants and helpers of the long-press pairing-mode timer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lppm_pkg;

  // Width of the hold and pairing counters
  localparam int unsigned COUNT_WIDTH = 16;
  // Width of each configuration register
  localparam int unsigned CFG_W = 16;
  // Width used for threshold compares
  localparam int unsigned CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [CFG_W-1:0]       cfg_val_t;
  typedef logic [CMP_W-1:0]       cmp_t;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_FORCE = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOLD    = 2'd0,
    REG_RESET   = 2'd1,
    REG_TIMEOUT = 2'd2,
    REG_BLINK   = 2'd3
  } cfg_idx_e;

  localparam cfg_val_t HOLD_RST    = CFG_W'(100);
  localparam cfg_val_t RESET_RST   = CFG_W'(140);
  localparam cfg_val_t TIMEOUT_RST = CFG_W'(1200);
  localparam cfg_val_t BLINK_RST   = CFG_W'(20);

  typedef struct packed {
    cfg_val_t hold_ticks;
    cfg_val_t reset_ticks;
    cfg_val_t timeout_ticks;
    cfg_val_t blink_ticks;
  } cfg_t;

  typedef struct packed {
    logic led_on_pulse;
    logic led_off_pulse;
    logic blink_pulse;
    logic forget_bonds_pulse;
    logic pairing_active;
    logic pairing_allowed;
  } res_t;

  // Saturating increment: a counter at its maximum stays there
  function automatic cnt_t sat_inc(input cnt_t v);
    sat_inc = (v == {COUNT_WIDTH{1'b1}}) ? v : cnt_t'(v + 1'b1);
  endfunction

  // Widen a counter for compares against thresholds
  function automatic cmp_t cnt_ext(input cnt_t v);
    cnt_ext = CMP_W'(v);
  endfunction

  // Widen a threshold for compares against counters
  function automatic cmp_t cfg_ext(input cfg_val_t v);
    cfg_ext = CMP_W'(v);
  endfunction

endpackage

### rtl/long_press_pairing_mode_timer_unit.sv
// ----------------------------------------------------------------------------
// long_press_pairing_mode_timer_unit
// Long-press button timer: LED, pairing-mode and forget-bonds events.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------
//  in      | in_valid_i / in_ready_o| op_i, button_pressed_i, force_value_i
//  out     | out_valid_o/out_ready_i| led_on/led_off/blink/forget pulses,
//          |                        | pairing_active_o, pairing_allowed_o
//  cfg     | cfg_we_i (no wait)     | cfg_idx_i, cfg_wdata_i
//
//  One transaction per cycle; its result appears in the result register in the
//  cycle after acceptance. The state update and the compares finish in the
//  acceptance cycle, so back-to-back ticks see the updated counters.
//  in_ready_o is low only while a result waits and out_ready_i is low.
//  Reset loads the threshold defaults and clears all counters and flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "long_press_pairing_mode_timer_unit_assert.svh"

module long_press_pairing_mode_timer_unit
  import lppm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 op_i,
  input  logic                 button_pressed_i,
  input  logic                 force_value_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 led_on_pulse_o,
  output logic                 led_off_pulse_o,
  output logic                 blink_pulse_o,
  output logic                 forget_bonds_pulse_o,
  output logic                 pairing_active_o,
  output logic                 pairing_allowed_o
);

  cfg_t cfg;
  res_t res;
  res_t res_q;
  logic out_valid_q, out_valid_d;
  logic in_fire;

  lppm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lppm_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .step_i           (in_fire),
    .op_i             (op_i),
    .button_pressed_i (button_pressed_i),
    .force_value_i    (force_value_i),
    .res_o            (res)
  );

  // Accept while the result register is empty or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the result of each accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign led_on_pulse_o       = res_q.led_on_pulse;
  assign led_off_pulse_o      = res_q.led_off_pulse;
  assign blink_pulse_o        = res_q.blink_pulse;
  assign forget_bonds_pulse_o = res_q.forget_bonds_pulse;
  assign pairing_active_o     = res_q.pairing_active;
  assign pairing_allowed_o    = res_q.pairing_allowed;

  // Stalled result blocks new input
  `LPPM_ASSERT_SAME(a_stall_blocks_in, out_valid_o && !out_ready_i, !in_ready_o)
  // Allowed flag never stands without the pairing flag
  `LPPM_ASSERT_SAME(a_allowed_needs_pairing, out_valid_o && pairing_allowed_o, pairing_active_o)
  // LED-on only comes from a press while pairing is off
  `LPPM_ASSERT_SAME(a_led_on_not_pairing, out_valid_o && led_on_pulse_o,
                    !pairing_active_o && !forget_bonds_pulse_o)
  // Accepted transaction leaves a valid result behind
  `LPPM_ASSERT_NEXT(a_fire_gives_result, in_valid_i && in_ready_o, out_valid_o)

endmodule

### rtl/lppm_cfg_regs.sv
// ----------------------------------------------------------------------------
// lppm_cfg_regs
// Threshold registers written through the plain configuration port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lppm_cfg_regs
  import lppm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Pick the register addressed by the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_HOLD:    cfg_d.hold_ticks    = cfg_wdata_i;
        REG_RESET:   cfg_d.reset_ticks   = cfg_wdata_i;
        REG_TIMEOUT: cfg_d.timeout_ticks = cfg_wdata_i;
        REG_BLINK:   cfg_d.blink_ticks   = cfg_wdata_i;
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  // Hold the thresholds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_ticks    <= HOLD_RST;
      cfg_q.reset_ticks   <= RESET_RST;
      cfg_q.timeout_ticks <= TIMEOUT_RST;
      cfg_q.blink_ticks   <= BLINK_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/lppm_core.sv
// ----------------------------------------------------------------------------
// lppm_core
// Hold, pairing and blink counters with the tick and force next-state logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lppm_core
  import lppm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic step_i,
  input  logic op_i,
  input  logic button_pressed_i,
  input  logic force_value_i,
  output res_t res_o
);

  cnt_t hold_q, hold_d;
  cnt_t pair_q, pair_d;
  cnt_t blink_q, blink_d;
  logic armed_q, armed_d;
  logic pair_flag_q, pair_flag_d;
  logic allowed_q, allowed_d;

  cmp_t hold_th, reset_th, timeout_th, blink_th;
  cnt_t hold_inc;
  cnt_t pair_inc, blink_inc;
  logic inc_in_win, inc_past_reset;
  logic old_in_win, old_past_reset;

  assign hold_th    = cfg_ext(cfg_i.hold_ticks);
  assign reset_th   = cfg_ext(cfg_i.reset_ticks);
  assign timeout_th = cfg_ext(cfg_i.timeout_ticks);
  assign blink_th   = cfg_ext(cfg_i.blink_ticks);

  // Window compares on the incremented and the held count
  assign hold_inc       = sat_inc(hold_q);
  assign inc_in_win     = (cnt_ext(hold_inc) >= hold_th) && (cnt_ext(hold_inc) < reset_th);
  assign inc_past_reset = cnt_ext(hold_inc) >= reset_th;
  assign old_in_win     = (cnt_ext(hold_q) >= hold_th) && (cnt_ext(hold_q) < reset_th);
  assign old_past_reset = cnt_ext(hold_q) >= reset_th;

  // Advance the state by one transaction
  always_comb begin
    hold_d      = hold_q;
    pair_d      = pair_q;
    blink_d     = blink_q;
    armed_d     = armed_q;
    pair_flag_d = pair_flag_q;
    allowed_d   = allowed_q;
    pair_inc    = pair_q;
    blink_inc   = blink_q;
    res_o       = '0;

    if (op_e'(op_i) == OP_FORCE) begin
      pair_flag_d = force_value_i;
      if (!force_value_i) begin
        allowed_d           = 1'b0;
        pair_d              = '0;
        blink_d             = '0;
        res_o.led_off_pulse = 1'b1;
      end
    end else begin
      if (button_pressed_i) begin
        hold_d = hold_inc;
        // Arm the window on entry; windows exclude the reset threshold
        if (inc_in_win && !pair_flag_q && !armed_q) begin
          res_o.led_on_pulse = 1'b1;
          armed_d            = 1'b1;
        end
        if (inc_past_reset && armed_q) begin
          res_o.led_off_pulse = 1'b1;
          armed_d             = 1'b0;
        end
      end else begin
        // Release inside the window enters pairing
        if (old_in_win && !pair_flag_q) begin
          armed_d     = 1'b0;
          pair_flag_d = 1'b1;
          allowed_d   = 1'b1;
          pair_d      = '0;
          blink_d     = '0;
        end
        res_o.forget_bonds_pulse = old_past_reset;
        hold_d                   = '0;
      end

      // Run the pairing timers
      if (pair_flag_d) begin
        pair_inc  = sat_inc(pair_d);
        blink_inc = sat_inc(blink_d);
        pair_d    = pair_inc;
        blink_d   = blink_inc;
        if (cnt_ext(blink_inc) >= blink_th) begin
          blink_d           = '0;
          res_o.blink_pulse = 1'b1;
        end
        if (cnt_ext(pair_inc) >= timeout_th) begin
          pair_flag_d         = 1'b0;
          allowed_d           = 1'b0;
          pair_d              = '0;
          blink_d             = '0;
          res_o.led_off_pulse = 1'b1;
        end
      end
    end

    res_o.pairing_active  = pair_flag_d;
    res_o.pairing_allowed = allowed_d;
  end

  // Update the state on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q      <= '0;
      pair_q      <= '0;
      blink_q     <= '0;
      armed_q     <= 1'b0;
      pair_flag_q <= 1'b0;
      allowed_q   <= 1'b0;
    end else if (step_i) begin
      hold_q      <= hold_d;
      pair_q      <= pair_d;
      blink_q     <= blink_d;
      armed_q     <= armed_d;
      pair_flag_q <= pair_flag_d;
      allowed_q   <= allowed_d;
    end
  end

endmodule
